/* rtl/core/gfau_pkg.sv */
// Package with the constants, operation codes and the bit-serial step of the GF(2^8) unit.
`default_nettype none

package gfau_pkg;

    // The field width is fixed by the widths of the element ports.
    localparam int FIELD_BITS = 8;
    localparam int EXP_BITS   = 32;
    localparam int CNT_BITS   = $clog2(FIELD_BITS);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    typedef logic [FIELD_BITS-1:0] elem_t;
    typedef logic [EXP_BITS-1:0]   exp_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [1:0]            func_t;

    localparam func_t FUNC_ADD = 2'd0;
    localparam func_t FUNC_MUL = 2'd1;
    localparam func_t FUNC_POW = 2'd2;
    localparam func_t FUNC_CMP = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_POLY = '0;

    localparam elem_t POLY_RESET = elem_t'(8'h1D);
    localparam elem_t ELEM_ONE   = elem_t'(1);
    localparam cnt_t  CNT_LAST   = cnt_t'(FIELD_BITS - 1);

    // One MSB-first step of a carry-less multiply with modular reduction.
    function automatic elem_t gf_step(input elem_t acc, input elem_t poly,
                                      input logic mbit, input elem_t mcand);
        elem_t shifted;
        shifted = {acc[FIELD_BITS-2:0], 1'b0};
        if (acc[FIELD_BITS-1]) begin
            shifted = shifted ^ poly;
        end
        if (mbit) begin
            shifted = shifted ^ mcand;
        end
        return shifted;
    endfunction

endpackage : gfau_pkg

`default_nettype wire

/* rtl/core/galois_field_arith_unit_top.sv */
// Top level of the GF(2^8) arithmetic unit: add, multiply, power and compare.
//
//  Channel   Direction  Handshake              Contents
//  s_*       in         s_valid / s_ready      s_func, s_operand_a, s_operand_b, s_exponent
//  m_*       out        m_valid / m_ready      m_value, m_is_equal
//  APB       in/out     psel, penable, pready  poly_low_bits at byte address 0
//
// Add and compare load the result register from the run state as soon as the
// output register is free. Multiply runs a single round; power runs one round
// per exponent bit up to and including the highest set one, and a zero exponent
// finishes like add. Rounds come from the bit-serial multiplier pair: one bit
// of the multiplier operand per cycle, with the product and the square sharing it.
// Reset (aresetn, synchronous, active low) empties the unit and restores the
// polynomial to 0x1D. A stalled result waits in the output register while
// the next transaction is already accepted; a second finished result waits
// inside the core until the output register frees.
`default_nettype none

module galois_field_arith_unit_top
    import gfau_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_func,
    input  wire logic [7:0]            s_operand_a,
    input  wire logic [7:0]            s_operand_b,
    input  wire logic [31:0]           s_exponent,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_value,
    output logic                       m_is_equal,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // One-hot controller: idle, running multiply rounds, holding a result.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    logic   m_valid_reg, m_valid_next;
    elem_t  poly_reg, poly_next;

    // Datapath registers. During power, t_reg is the running product and
    // base_reg the running square; bs_reg streams the bits of the base,
    // MSB first, into both multiplier lanes at once. A multiply is treated
    // as a single round with t_reg holding operand_a and bs_reg operand_b.
    elem_t  t_reg, t_next;
    elem_t  base_reg, base_next;
    elem_t  bs_reg, bs_next;
    elem_t  acc_t_reg, acc_t_next;
    elem_t  acc_b_reg, acc_b_next;
    exp_t   exp_reg, exp_next;
    logic   eq_reg, eq_next;
    elem_t  out_value_reg, out_value_next;
    logic   out_eq_reg, out_eq_next;

    elem_t  step_t;
    elem_t  step_b;
    logic   out_free;
    logic   cfg_write;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_value    = out_value_reg;
    assign m_is_equal = out_eq_reg;

    // Both lanes consume the same streamed bit in the same cycle.
    assign step_t = gf_step(acc_t_reg, poly_reg, bs_reg[FIELD_BITS-1], t_reg);
    assign step_b = gf_step(acc_b_reg, poly_reg, bs_reg[FIELD_BITS-1], base_reg);

    // Configuration port: only the polynomial register lives at address 0;
    // writes elsewhere are dropped and reads elsewhere return zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign poly_next = (cfg_write && (paddr == ADDR_POLY)) ? pwdata[FIELD_BITS-1:0] : poly_reg;
    assign prdata    = (paddr == ADDR_POLY) ? APB_DATA_W'(poly_reg) : '0;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        t_next         = t_reg;
        base_next      = base_reg;
        bs_next        = bs_reg;
        acc_t_next     = acc_t_reg;
        acc_b_next     = acc_b_reg;
        exp_next       = exp_reg;
        eq_next        = eq_reg;
        out_value_next = out_value_reg;
        out_eq_next    = out_eq_reg;

        // The downstream side drains the output register independently.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    acc_t_next = '0;
                    acc_b_next = '0;
                    cnt_next   = '0;
                    base_next  = s_operand_b;
                    bs_next    = s_operand_b;
                    eq_next    = 1'b0;
                    state_next = ST_RUN;
                    case (s_func)
                        FUNC_ADD: begin
                            t_next   = s_operand_a ^ s_operand_b;
                            exp_next = '0;
                        end
                        FUNC_MUL: begin
                            t_next   = s_operand_a;
                            exp_next = exp_t'(1);
                        end
                        FUNC_POW: begin
                            t_next    = ELEM_ONE;
                            base_next = s_operand_a;
                            bs_next   = s_operand_a;
                            exp_next  = s_exponent;
                        end
                        default: begin
                            t_next   = '0;
                            exp_next = '0;
                            eq_next  = (s_operand_a == s_operand_b);
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (exp_reg == '0) begin
                    // No exponent bits remain: t_reg holds the answer.
                    if (out_free) begin
                        out_value_next = t_reg;
                        out_eq_next    = eq_reg;
                        m_valid_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                    end
                end else begin
                    acc_t_next = step_t;
                    acc_b_next = step_b;
                    bs_next    = {bs_reg[FIELD_BITS-2:0], 1'b0};
                    cnt_next   = cnt_reg + cnt_t'(1);
                    if (cnt_reg == CNT_LAST) begin
                        // End of a round: keep the product when the exponent
                        // bit is set, and square the base for the next bit.
                        cnt_next   = '0;
                        acc_t_next = '0;
                        acc_b_next = '0;
                        if (exp_reg[0]) begin
                            t_next = step_t;
                        end
                        base_next = step_b;
                        bs_next   = step_b;
                        exp_next  = exp_reg >> 1;
                    end
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    out_value_next = t_reg;
                    out_eq_next    = eq_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            poly_reg    <= POLY_RESET;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            poly_reg    <= poly_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg         <= t_next;
        base_reg      <= base_next;
        bs_reg        <= bs_next;
        acc_t_reg     <= acc_t_next;
        acc_b_reg     <= acc_b_next;
        exp_reg       <= exp_next;
        eq_reg        <= eq_next;
        out_value_reg <= out_value_next;
        out_eq_reg    <= out_eq_next;
    end

    // A round in progress always has exponent bits left to consume.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg != '0) |-> (exp_reg != '0))
        else $error("multiply round running with an empty exponent");

    // Add and compare finish without any multiply round.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_ADD || s_func == FUNC_CMP))
        |=> (exp_reg == '0 && cnt_reg == '0))
        else $error("add or compare scheduled a multiply round");

    // A multiply is exactly one round.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == FUNC_MUL) |=> (exp_reg == exp_t'(1)))
        else $error("multiply did not schedule exactly one round");

    // A true compare result never carries a field value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_eq_reg) |-> (out_value_reg == '0))
        else $error("compare result carries a nonzero value");

endmodule : galois_field_arith_unit_top

`default_nettype wire

/* verif/galois_field_arith_unit_checker.sv */
// Checker that predicts and compares every result of the GF(2^8) arithmetic unit.
module galois_field_arith_unit_checker
    import gfau_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  func_t                 s_func,
    input  elem_t                 s_operand_a,
    input  elem_t                 s_operand_b,
    input  exp_t                  s_exponent,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  elem_t                 m_value,
    input  logic                  m_is_equal,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    error_count,
    output int                    pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        elem_t value;
        logic  is_equal;
    } gf_result_t;

    elem_t      poly_shadow;
    gf_result_t expected_results[$];
    gf_result_t want;

    // Multiply by x, folding the implied x^8 term back in through the polynomial.
    function automatic elem_t times_x(input elem_t x, input elem_t poly);
        return x[FIELD_BITS-1] ? ({x[FIELD_BITS-2:0], 1'b0} ^ poly)
                               : {x[FIELD_BITS-2:0], 1'b0};
    endfunction

    function automatic elem_t field_product(input elem_t a, input elem_t b, input elem_t poly);
        elem_t sum;
        elem_t shifted;
        sum     = '0;
        shifted = a;
        for (int i = 0; i < FIELD_BITS; i++) begin
            if (b[i]) begin
                sum = sum ^ shifted;
            end
            shifted = times_x(shifted, poly);
        end
        return sum;
    endfunction

    function automatic elem_t field_power(input elem_t a, input exp_t e, input elem_t poly);
        elem_t acc;
        elem_t base;
        acc  = ELEM_ONE;
        base = a;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (e[i]) begin
                acc = field_product(acc, base, poly);
            end
            base = field_product(base, base, poly);
        end
        return acc;
    endfunction

    function automatic gf_result_t predict_result(input func_t f, input elem_t a,
                                                  input elem_t b, input exp_t e,
                                                  input elem_t poly);
        gf_result_t r;
        r = '0;
        case (f)
            FUNC_ADD: begin
                r.value = a ^ b;
            end
            FUNC_MUL: begin
                r.value = field_product(a, b, poly);
            end
            FUNC_POW: begin
                r.value = field_power(a, e, poly);
            end
            default: begin
                r.is_equal = (a == b);
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            poly_shadow = POLY_RESET;
            error_count = 0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_POLY) begin
                poly_shadow = pwdata[FIELD_BITS-1:0];
            end
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(),
                                        predict_result(s_func, s_operand_a, s_operand_b,
                                                       s_exponent, poly_shadow));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: value %0h is_equal %0b", m_value, m_is_equal);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_value !== want.value) begin
                        $error("value mismatch: expected %0h, got %0h", want.value, m_value);
                        error_count++;
                    end
                    if (m_is_equal !== want.is_equal) begin
                        $error("is_equal mismatch: expected %0b, got %0b",
                               want.is_equal, m_is_equal);
                        error_count++;
                    end
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

/* verif/testbench.sv */
// Top of the GF(2^8) arithmetic unit testbench: clock, reset, stimulus and verdict.
module testbench;
    import gfau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The slowest correct run comes from long power transactions and from the
    // receiver, which stalls most of the time in two of the six phases. The
    // limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int ITEMS_PER_MODE = 175;
    localparam int DRAIN_CYCLES   = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    func_t                 s_func;
    elem_t                 s_operand_a;
    elem_t                 s_operand_b;
    exp_t                  s_exponent;
    logic                  m_valid;
    logic                  m_ready;
    elem_t                 m_value;
    logic                  m_is_equal;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int error_count;
    int pending_results;
    int cycle_count = 0;

    // Percentage of cycles in which each side holds back. The stimulus process
    // changes these between phases so that gaps land on every step of a
    // multiply or power, and the last phases run without any gaps at all.
    int sender_idle_pct   = 15;
    int receiver_idle_pct = 87;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    galois_field_arith_unit_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_exponent  (s_exponent),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_is_equal  (m_is_equal),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    galois_field_arith_unit_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_operand_a     (s_operand_a),
        .s_operand_b     (s_operand_b),
        .s_exponent      (s_exponent),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_is_equal      (m_is_equal),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // The receiver decides afresh at every edge whether it can take a result.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one transaction and returns right after the edge that accepted
    // it. The handshake is sampled at the falling edge, when every input is
    // settled, so the decision does not depend on event order at the rising
    // edge. Valid is left high on return; the next call either keeps it high
    // for back-to-back transactions or lowers it when it decides to idle.
    task automatic send_op(input func_t f, input elem_t a, input elem_t b, input exp_t e);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_operand_a <= a;
        s_operand_b <= b;
        s_exponent  <= e;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // A register write: a setup phase, then an access phase. pready is always high,
    // so the register takes the data at the end of the access cycle.
    task automatic write_poly(input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POLY;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Operands lean toward 0, 1 and all-ones, where the reduction and the
    // zero-base rules are most likely to go wrong.
    function automatic elem_t pick_element();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ELEM_ONE;
            2:       return '1;
            default: return elem_t'($urandom);
        endcase
    endfunction

    // Exponents mix small values, single set bits, all ones and full-range
    // random words, so every exponent bit is seen both set and clear.
    function automatic exp_t pick_exponent();
        case ($urandom_range(5))
            0:       return exp_t'($urandom_range(20));
            1:       return exp_t'(1) << $urandom_range(EXP_BITS - 1);
            2:       return '1;
            default: return exp_t'($urandom);
        endcase
    endfunction

    task automatic send_random_op();
        func_t f;
        elem_t a;
        elem_t b;
        f = func_t'($urandom_range(3));
        a = pick_element();
        b = pick_element();
        // Half of the compares use equal operands, or a match would be rare.
        if (f == FUNC_CMP && $urandom_range(1) == 1) begin
            b = a;
        end
        send_op(f, a, b, pick_exponent());
    endtask

    // Sends a batch of random transactions, then lowers valid and waits at a
    // falling edge until the checker has seen every result come back. Only
    // then is the block idle and safe to reconfigure.
    task automatic run_random_batch(input int count);
        repeat (count) begin
            send_random_op();
        end
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (pending_results != 0);
        @(posedge aclk);
    endtask

    initial begin
        // Every input gets a known value before the first edge.
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_func      <= FUNC_ADD;
        s_operand_a <= '0;
        s_operand_b <= '0;
        s_exponent  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= ADDR_POLY;
        pwdata      <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed transactions under the reset polynomial 0x11D.
        send_op(FUNC_ADD, 8'h00, 8'h00, 32'h0000_0000);
        send_op(FUNC_ADD, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(FUNC_ADD, 8'hA5, 8'h5A, 32'h0000_0000);
        send_op(FUNC_MUL, 8'h00, 8'hFF, 32'h0000_0000);
        send_op(FUNC_MUL, 8'hFF, 8'hFF, 32'h0000_0000);
        send_op(FUNC_MUL, 8'h01, 8'hB7, 32'h0000_0000);
        send_op(FUNC_MUL, 8'h80, 8'h02, 32'h0000_0000);
        send_op(FUNC_MUL, 8'h53, 8'hCA, 32'h0000_0000);
        // A zero base gives one for a zero exponent and zero for any other.
        send_op(FUNC_POW, 8'h00, 8'h00, 32'h0000_0000);
        send_op(FUNC_POW, 8'h00, 8'hFF, 32'h0000_0001);
        send_op(FUNC_POW, 8'h00, 8'h00, 32'hFFFF_FFFF);
        send_op(FUNC_POW, 8'h02, 8'h00, 32'h0000_0000);
        send_op(FUNC_POW, 8'h02, 8'h00, 32'h0000_0001);
        send_op(FUNC_POW, 8'h02, 8'h00, 32'h0000_00FF);
        send_op(FUNC_POW, 8'hFF, 8'h00, 32'hFFFF_FFFF);
        send_op(FUNC_POW, 8'h03, 8'h00, 32'h8000_0000);
        send_op(FUNC_POW, 8'h1D, 8'h00, 32'h0000_0002);
        // Compares: the value field must stay zero, and is_equal must stay
        // zero for every other operation above.
        send_op(FUNC_CMP, 8'h00, 8'h00, 32'h0000_0000);
        send_op(FUNC_CMP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(FUNC_CMP, 8'hFF, 8'hFE, 32'h0000_0000);
        send_op(FUNC_CMP, 8'h00, 8'h80, 32'h0000_0000);
        send_op(FUNC_CMP, 8'h5A, 8'hA5, 32'h0000_0000);

        // Sender mostly busy, receiver mostly stalled: results back up.
        sender_idle_pct   = 15;
        receiver_idle_pct = 87;
        run_random_batch(ITEMS_PER_MODE);
        write_poly(32'h0000_0000);
        run_random_batch(ITEMS_PER_MODE);

        // Roles swapped: the block mostly waits on new transactions.
        sender_idle_pct   = 87;
        receiver_idle_pct = 15;
        write_poly(32'h0000_00FF);
        run_random_batch(ITEMS_PER_MODE);
        write_poly(32'h0000_001B);
        run_random_batch(ITEMS_PER_MODE);

        // No gaps on either side. The upper data bits carry random junk that
        // the register must drop.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_poly($urandom);
        run_random_batch(ITEMS_PER_MODE);
        write_poly({16'($urandom_range(16'hFFFF, 0)), 16'h001D});
        run_random_batch(ITEMS_PER_MODE);

        // Everything has drained; keep watching for stray results for longer
        // than the slowest power takes.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* galois_field_arith_unit_top.f */
rtl/core/gfau_pkg.sv
rtl/core/galois_field_arith_unit_top.sv
verif/galois_field_arith_unit_checker.sv
verif/testbench.sv
